>>> rtl/core/ffba_pkg.sv
package ffba_pkg;

   localparam int NUM_BLOCKS_DEF  = 512;
   localparam int BLOCK_BYTES_DEF = 100;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [1:0] {
      MAP_IDLE     = 2'd0,
      MAP_HEAD     = 2'd1,
      MAP_ATTACHED = 2'd2
   } map_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic       command;
      logic [15:0] request_bytes;
      logic [8:0] block_index;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [8:0] start_block;
   } rsp_type;

   // token flags walking down the cell chain
   typedef struct packed {
      logic valid;
      logic op;
      logic active;
      logic found;
   } tok_type;

endpackage

>>> rtl/core/first_fit_block_allocator.sv
// A fitting allocate sends the scan token down the whole cell chain one cell
// per cycle, then passes the mark state; a free or failed allocate ends as the
// token leaves the chain. An oversized allocate fails in idle, busy staying low.
// Throughput: one request at a time; else busy is high until the result strobe.
// Reset: synchronous, clears all map entries to idle and the controller to idle.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   // floor divide by BLOCK_BYTES via reciprocal multiply, exact below 2**17
   localparam int QW  = 17;
   localparam int QSH = QW + $clog2(BLOCK_BYTES);
   localparam logic [QW:0] RECIP =
      (QW+1)'(((64'd1 << QSH) / 64'(BLOCK_BYTES)) + 64'd1);

   state_type     state_ff, state_in;
   logic          inj_ff;
   logic          op_ff;
   logic [CW-1:0] need_ff;
   logic [8:0]    idx_ff;
   logic [IW-1:0] lo_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          mark_go;
   logic          accept;
   logic [QW-1:0] bytes_plus;
   logic [2*QW:0] need_prod;
   logic [31:0]   need_full;
   logic          oversize;

   tok_type       tok   [0:NUM_BLOCKS];
   logic [CW-1:0] run   [0:NUM_BLOCKS];
   logic [IW-1:0] start_v [0:NUM_BLOCKS];

   assign accept     = start && !busy;
   assign bytes_plus = QW'(req_item.request_bytes) + QW'(BLOCK_BYTES);
   assign need_prod  = (2*QW+1)'(bytes_plus) * (2*QW+1)'(RECIP);
   assign need_full  = 32'(need_prod >> QSH);
   assign oversize   = need_full > 32'(NUM_BLOCKS);

   assign tok[0]     = '{valid: inj_ff, op: op_ff, active: 1'b0, found: 1'b0};
   assign run[0]     = '0;
   assign start_v[0] = '0;

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      ffba_cell #(
         .CELL_INDEX(g),
         .IW(IW),
         .CW(CW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .tok_in(tok[g]),
         .run_in(run[g]),
         .start_in(start_v[g]),
         .need(need_ff),
         .free_idx(idx_ff),
         .mark_go(mark_go),
         .mark_lo(lo_ff),
         .tok_out(tok[g+1]),
         .run_out(run[g+1]),
         .start_out(start_v[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !(req_item.command == CMD_ALLOC && oversize)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok[NUM_BLOCKS].valid) begin
               state_in = (op_ff == CMD_ALLOC && tok[NUM_BLOCKS].found) ? ST_MARK : ST_IDLE;
            end
         end
         ST_MARK: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = 1'b1;
      mark_go      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: STATUS_OK, start_block: 9'd0};
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept && req_item.command == CMD_ALLOC && oversize) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = STATUS_FAIL;
            end
         end
         ST_SCAN: begin
            if (tok[NUM_BLOCKS].valid) begin
               if (op_ff == CMD_FREE) begin
                  rsp_valid_in = 1'b1;
               end else if (!tok[NUM_BLOCKS].found) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_FAIL;
               end
            end
         end
         ST_MARK: begin
            mark_go            = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_in.start_block = 9'(lo_ff);
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inj_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inj_ff       <= accept && !(req_item.command == CMD_ALLOC && oversize);
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff   <= req_item.command;
         need_ff <= CW'(need_full);
         idx_ff  <= req_item.block_index;
      end
      if (state_ff == ST_SCAN && tok[NUM_BLOCKS].valid) begin
         lo_ff <= start_v[NUM_BLOCKS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_FAIL) |-> rsp_item.start_block == 9'd0)
      else $error("failed allocate with nonzero start");
   a_tail_scan: assert property (@(posedge clock) disable iff (reset)
      tok[NUM_BLOCKS].valid |-> state_ff == ST_SCAN) else $error("token out of scan");
   a_mark_rsp: assert property (@(posedge clock) disable iff (reset)
      mark_go |=> rsp_valid) else $error("mark without result");
`endif

endmodule

>>> rtl/core/ffba_cell.sv
module ffba_cell
   import ffba_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int IW = 9,
   parameter int CW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  tok_type       tok_in,
   input  logic [CW-1:0] run_in,
   input  logic [IW-1:0] start_in,
   input  logic [CW-1:0] need,
   input  logic [8:0]    free_idx,
   input  logic          mark_go,
   input  logic [IW-1:0] mark_lo,
   output tok_type       tok_out,
   output logic [CW-1:0] run_out,
   output logic [IW-1:0] start_out
);

   localparam int MW = (IW > 9) ? IW : 9;
   localparam logic [IW:0] IDX_W = (IW+1)'(CELL_INDEX);

   map_type       entry_ff, entry_in;
   tok_type       tok_ff, tok_in_next;
   logic [CW-1:0] run_ff, run_in_next;
   logic [IW-1:0] start_ff, start_in_next;
   logic [CW-1:0] run_here;
   logic [IW:0]   lo_ext, hi_ext;
   logic          in_range;

   always_comb begin
      entry_in      = entry_ff;
      tok_in_next   = '0;
      run_in_next   = run_in;
      start_in_next = start_in;
      run_here      = run_in + CW'(1);
      lo_ext        = {1'b0, mark_lo};
      hi_ext        = lo_ext + (IW+1)'(need);
      in_range      = (IDX_W >= lo_ext) && (IDX_W < hi_ext);
      if (tok_in.valid) begin
         tok_in_next = tok_in;
         if (tok_in.op == CMD_FREE) begin
            if (MW'(free_idx) == MW'(CELL_INDEX)) begin
               entry_in           = MAP_IDLE;
               tok_in_next.active = 1'b1;
            end else if (tok_in.active && entry_ff == MAP_ATTACHED) begin
               entry_in           = MAP_IDLE;
               tok_in_next.active = 1'b1;
            end else begin
               tok_in_next.active = 1'b0;
            end
         end else if (!tok_in.found) begin
            if (entry_ff == MAP_IDLE) begin
               run_in_next = run_here;
               if (run_here == need) begin
                  tok_in_next.found = 1'b1;
                  start_in_next = IW'((IW+1)'(CELL_INDEX + 1) - (IW+1)'(need));
               end
            end else begin
               run_in_next = '0;
            end
         end
      end
      if (mark_go && in_range) begin
         entry_in = (IDX_W == lo_ext) ? MAP_HEAD : MAP_ATTACHED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= MAP_IDLE;
         tok_ff   <= '0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in_next;
      end
      run_ff   <= run_in_next;
      start_ff <= start_in_next;
   end

   assign tok_out   = tok_ff;
   assign run_out   = run_ff;
   assign start_out = start_ff;

endmodule
